// ===== rtl/lfr_pkg.sv =====
package lfr_pkg;

    localparam int WORD_W = 64;
    localparam int LAG_W  = 6;
    localparam int INT_W  = 31;
    localparam int FRAC_W = 52;
    localparam int LCG_W  = 45;

    // LCG multiplier split at bit 23 for the partial products
    localparam int LO_W = 23;
    localparam int HI_W = LCG_W - LO_W;

    localparam int LAG_VALUES = 1 << LAG_W;
    localparam int LAG_RESET  = 31;

    localparam int INT_LSB  = 15;
    localparam int FRAC_LSB = WORD_W - FRAC_W;

    localparam logic [34:0]      LCG_MUL    = 35'd25214903917;
    localparam logic [LO_W-1:0]  LCG_MUL_LO = LCG_MUL[LO_W-1:0];
    localparam logic [11:0]      LCG_MUL_HI = LCG_MUL[34:LO_W];
    localparam logic [LCG_W-1:0] LCG_ADD    = 45'd11;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_ROT  = 4'b1000
    } lfr_state_t;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic add_en;
    } lcg_ctrl_t;

endpackage

// ===== rtl/lagged_fibonacci_rng.sv =====
// Additive lagged Fibonacci generator, ring of RING_DEPTH 64-bit words.
// Input channel (in_valid / in_stall): a transfer carries opcode and
// seed_value. A next item (opcode 1) yields one result; a seed item
// (opcode 0) refills the ring and yields none.
// Output channel (out_valid / out_stall): int_value and fraction of the
// new ring word, held in an output register.
// Config channel (cfg_valid / cfg_ready): cfg_data sets short_lag;
// cfg_ready is always high, write only while the block is idle.
// Latency: a next result appears in the cycle after its transfer.
// Throughput: one next item per cycle while idle; in_stall rises for a next item
// also while a result waits and out_stall is high (seeds still pass).
// Seed: the ring is a rotating chain of cells. The seed word is shifted
// in, then each LCG entry passes ST_MUL (partial products) and ST_ADD (sum),
// then the chain rotates (wp+1) mod RING_DEPTH times to line up with the
// write pointer. in_stall stays high after a seed transfer until the block
// is back in ST_IDLE.
// Reset: ring zero, write pointer zero, short_lag 31, no result pending.
module lagged_fibonacci_rng
    import lfr_pkg::*;
#(
    parameter int RING_DEPTH = 63
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic [WORD_W-1:0] seed_value,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [INT_W-1:0]  int_value,
    output logic [FRAC_W-1:0] fraction,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LAG_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam int TapReset = ((LAG_RESET % RING_DEPTH) + RING_DEPTH - 1) % RING_DEPTH;

    // Cell k holds ring[(wp - k) mod RING_DEPTH]. The entry to overwrite
    // next sits in the last cell; the lagged entry at a fixed tap.
    logic [WORD_W-1:0] cell_q [RING_DEPTH];
    logic [WORD_W-1:0] head_d;
    logic              shift;

    lfr_state_t       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] wp_reg, wp_next;
    logic [IDX_W-1:0] tap_idx_reg, tap_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic [INT_W-1:0]  int_reg;
    logic [FRAC_W-1:0] frac_reg;
    logic             load_out;

    logic [IDX_W-1:0]  tap_tbl [LAG_VALUES];
    logic [IDX_W-1:0]  wp_inc;
    logic [WORD_W-1:0] new_word;
    logic              in_xfer;
    lcg_ctrl_t         lcg_ctrl;
    logic [LCG_W-1:0]  lcg_s;

    // lag -> tap cell, lag taken mod depth, lag zero doubles the word
    for (genvar l = 0; l < LAG_VALUES; l++)
    begin : g_tap
        localparam int TapIdx = ((l % RING_DEPTH) + RING_DEPTH - 1) % RING_DEPTH;
        assign tap_tbl[l] = IDX_W'(TapIdx);
    end

    for (genvar k = 0; k < RING_DEPTH; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            lfr_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (head_d),
                .q     (cell_q[k])
            );
        end
        else
        begin : g_body
            lfr_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .shift (shift),
                .d     (cell_q[k-1]),
                .q     (cell_q[k])
            );
        end
    end

    lfr_lcg u_lcg (
        .clk   (clk),
        .ctrl  (lcg_ctrl),
        .seed  (seed_value),
        .s_new (lcg_s)
    );

    assign new_word = cell_q[RING_DEPTH-1] + cell_q[tap_idx_reg];
    assign wp_inc   = (wp_reg == LAST_IDX) ? '0 : wp_reg + 1'b1;

    assign in_stall = (state_reg != ST_IDLE)
                   || ((opcode == OP_NEXT) && out_valid_reg && out_stall);
    assign in_xfer  = in_valid && !in_stall;

    assign cfg_ready    = 1'b1;
    assign tap_idx_next = cfg_valid ? tap_tbl[cfg_data] : tap_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        wp_next        = wp_reg;
        shift          = 1'b0;
        head_d         = new_word;
        lcg_ctrl       = '0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    shift = 1'b1;
                    if (opcode == OP_NEXT)
                    begin
                        head_d         = new_word;
                        wp_next        = wp_inc;
                        load_out       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        // ring[0] gets the seed word as is
                        head_d        = seed_value;
                        lcg_ctrl.load = 1'b1;
                        cnt_next      = IDX_W'(1);
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                lcg_ctrl.mul_en = 1'b1;
                state_next      = ST_ADD;
            end
            ST_ADD:
            begin
                shift           = 1'b1;
                head_d          = {{(WORD_W-LCG_W){1'b0}}, lcg_s};
                lcg_ctrl.add_en = 1'b1;
                if (cnt_reg == LAST_IDX)
                begin
                    // chain now lines up as if wp were the last index
                    cnt_next   = '0;
                    state_next = (wp_reg == LAST_IDX) ? ST_IDLE : ST_ROT;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_ROT:
            begin
                shift  = 1'b1;
                head_d = cell_q[RING_DEPTH-1];
                if (cnt_reg == wp_reg)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            wp_reg        <= '0;
            tap_idx_reg   <= IDX_W'(TapReset);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            wp_reg        <= wp_next;
            tap_idx_reg   <= tap_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            int_reg  <= new_word[INT_LSB+INT_W-1:INT_LSB];
            frac_reg <= new_word[WORD_W-1:FRAC_LSB];
        end
    end

    assign out_valid = out_valid_reg;
    assign int_value = int_reg;
    assign fraction  = frac_reg;

endmodule

// ===== rtl/lfr_cell.sv =====
module lfr_cell
    import lfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic [WORD_W-1:0] d,
    output logic [WORD_W-1:0] q
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    assign word_next = shift ? d : word_reg;

    // ring entries reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign q = word_reg;

endmodule

// ===== rtl/lfr_lcg.sv =====
module lfr_lcg
    import lfr_pkg::*;
(
    input  logic              clk,
    input  lcg_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] seed,
    output logic [LCG_W-1:0]  s_new
);

    logic [LCG_W-1:0] s_reg;
    logic [LCG_W-1:0] s_next;
    logic [LCG_W-1:0] pll_reg;
    logic [HI_W-1:0]  c1_reg;
    logic [HI_W-1:0]  c2_reg;

    logic [LO_W-1:0]     s_lo;
    logic [HI_W-1:0]     s_hi;
    logic [2*LO_W-1:0]   pll_full;
    logic [34:0]         c1_full;
    logic [LCG_W-1:0]    c2_full;
    logic [HI_W-1:0]     c_sum;

    assign s_lo = s_reg[LO_W-1:0];
    assign s_hi = s_reg[LCG_W-1:LO_W];

    // lo*lo plus both cross terms; hi*hi falls above bit 45
    assign pll_full = {{(LO_W){1'b0}}, s_lo} * {{(LO_W){1'b0}}, LCG_MUL_LO};
    assign c1_full  = {12'b0, s_lo} * {23'b0, LCG_MUL_HI};
    assign c2_full  = {{(LO_W){1'b0}}, s_hi} * {{(HI_W){1'b0}}, LCG_MUL_LO};

    assign c_sum = c1_reg + c2_reg;
    assign s_new = pll_reg + {c_sum, {(LO_W){1'b0}}} + LCG_ADD;

    always_comb
    begin
        s_next = s_reg;
        if (ctrl.load)
        begin
            s_next = seed[LCG_W-1:0];
        end
        else if (ctrl.add_en)
        begin
            s_next = s_new;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        if (ctrl.mul_en)
        begin
            pll_reg <= pll_full[LCG_W-1:0];
            c1_reg  <= c1_full[HI_W-1:0];
            c2_reg  <= c2_full[HI_W-1:0];
        end
    end

endmodule
